/* src/rmq_pkg.sv */
// Package for the rotation matrix to quaternion block: formats, widths and shared types.
`default_nettype none
package rmq_pkg;
  localparam int FRAC_BITS_DEF  = 14;
  localparam int DATA_WIDTH_DEF = 16;
  localparam int DW = DATA_WIDTH_DEF;

  typedef struct packed {
    logic signed [DW-1:0] elem_00;
    logic signed [DW-1:0] elem_01;
    logic signed [DW-1:0] elem_02;
    logic signed [DW-1:0] elem_10;
    logic signed [DW-1:0] elem_11;
    logic signed [DW-1:0] elem_12;
    logic signed [DW-1:0] elem_20;
    logic signed [DW-1:0] elem_21;
    logic signed [DW-1:0] elem_22;
  } in_word_t;

  typedef struct packed {
    logic signed [DW-1:0] quat_w;
    logic signed [DW-1:0] quat_x;
    logic signed [DW-1:0] quat_y;
    logic signed [DW-1:0] quat_z;
    logic                 degenerate;
  } out_word_t;

  typedef enum logic [1:0] {
    SEL_W = 2'd0,
    SEL_X = 2'd1,
    SEL_Y = 2'd2,
    SEL_Z = 2'd3
  } sel_t;
endpackage
`default_nettype wire

/* src/rmq_sqrt.sv */
// Pipelined restoring square root, one result bit per stage.
`default_nettype none
module rmq_sqrt #(
  parameter int IW = 34,
  parameter int PW = 8
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [IW-1:0] rad,
  input  wire logic [PW-1:0] pass_in,
  output logic [IW/2-1:0]    root,
  output logic [PW-1:0]      pass_out
);
  localparam int N  = IW / 2;
  localparam int RW = N + 2;

  logic [IW-1:0] rem_v [0:N];
  logic [RW-1:0] acc_r [0:N];
  logic [N-1:0]  res_v [0:N];
  logic [PW-1:0] pas_v [0:N];

  assign rem_v[0] = rad;
  assign acc_r[0] = '0;
  assign res_v[0] = '0;
  assign pas_v[0] = pass_in;

  // Advance one digit pair per stage, hold while the pipe is stalled
  for (genvar i = 0; i < N; i++) begin : g_st
    logic [RW-1:0] tr;
    logic [RW-1:0] trial;
    logic          ok;
    assign tr    = {acc_r[i][RW-3:0], rem_v[i][IW-1 -: 2]};
    assign trial = {res_v[i], 2'b01};
    assign ok    = tr >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[i+1] <= ok ? tr - trial : tr;
        rem_v[i+1] <= {rem_v[i][IW-3:0], 2'b00};
        res_v[i+1] <= {res_v[i][N-2:0], ok};
        pas_v[i+1] <= pas_v[i];
      end
    end
  end

  assign root     = res_v[N];
  assign pass_out = pas_v[N];
endmodule
`default_nettype wire

/* src/rmq_div_lane.sv */
// One divider lane: signed numerator shifted by the fraction, restoring divide, saturate.
`default_nettype none
module rmq_div_lane #(
  parameter int NW = 19,
  parameter int DVW = 18,
  parameter int FB = 14,
  parameter int DWP = 16
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic signed [NW-1:0]  num,
  input  wire logic [DVW-1:0]        den,
  output logic signed [DWP-1:0]      quo
);
  localparam int QW = NW + FB;

  logic [QW-1:0]  dvd_v [0:QW];
  logic [DVW:0]   rem_v [0:QW];
  logic [DVW-1:0] den_v [0:QW];
  logic           neg_v [0:QW];
  logic [NW-1:0]  mag;

  assign mag      = num[NW-1] ? NW'(-num) : NW'(num);
  assign dvd_v[0] = {mag, {FB{1'b0}}};
  assign rem_v[0] = '0;
  assign den_v[0] = den;
  assign neg_v[0] = num[NW-1];

  // Advance one quotient bit per stage; quotient bits shift into dvd
  for (genvar i = 0; i < QW; i++) begin : g_st
    logic [DVW+1:0] tr;
    logic           ok;
    assign tr = {rem_v[i], dvd_v[i][QW-1]};
    assign ok = tr >= {2'b00, den_v[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_v[i+1] <= ok ? (DVW+1)'(tr - {2'b00, den_v[i]}) : (DVW+1)'(tr);
        dvd_v[i+1] <= {dvd_v[i][QW-2:0], ok};
        den_v[i+1] <= den_v[i];
        neg_v[i+1] <= neg_v[i];
      end
    end
  end

  // Saturate to the signed output range
  localparam logic [QW-1:0] HI = QW'((64'd1 << (DWP-1)) - 1);
  always_comb begin
    if (neg_v[QW]) begin
      quo = (dvd_v[QW] > HI) ? {1'b1, {(DWP-1){1'b0}}} : DWP'(-dvd_v[QW]);
    end else begin
      quo = (dvd_v[QW] > HI) ? {1'b0, {(DWP-1){1'b1}}} : DWP'(dvd_v[QW]);
    end
  end
endmodule
`default_nettype wire

/* src/rotation_matrix_to_quaternion.sv */
// Top level: branch selection, square root, three parallel divider lanes, merge.
// One matrix enters per clock while the pipeline advances; the quaternion passes through
// (DATA_WIDTH+FRAC_BITS+4)/2 square-root stages plus DATA_WIDTH+3+FRAC_BITS divider
// stages plus three register stages. The pipeline advances whenever the output register
// is free or being taken, so sustained rate is one word per cycle. When the divisor is
// zero the word still comes out: all components read zero and degenerate is set.
`default_nettype none
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire rmq_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rmq_pkg::out_word_t      out_data
);
  import rmq_pkg::*;

  localparam int EW  = DW + 3;           // radicand / numerator width
  localparam int SIW = 2 * ((EW + FRAC_BITS + 1) / 2);
  localparam int RTW = SIW / 2;
  localparam int DVW = RTW + 2;
  localparam int SQL = RTW;
  localparam int DVL = EW + FRAC_BITS;
  localparam int LAT = 1 + SQL + 1 + DVL;
  localparam int PW  = 2 + 3 * EW;

  // Stall the whole pipe only when the output register holds an untaken word
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  logic [LAT-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // Stage 0: trace, branch and radicand, numerators
  logic signed [EW-1:0] e00, e11, e22, tr, one, rad;
  logic signed [EW-1:0] n0, n1, n2;
  sel_t sel;
  always_comb begin
    e00 = EW'(in_data.elem_00);
    e11 = EW'(in_data.elem_11);
    e22 = EW'(in_data.elem_22);
    one = EW'(1) <<< FRAC_BITS;
    tr  = e00 + e11 + e22;
    if (tr > 0) begin
      sel = SEL_W; rad = one + tr;
      n0 = EW'(in_data.elem_21) - EW'(in_data.elem_12);
      n1 = EW'(in_data.elem_02) - EW'(in_data.elem_20);
      n2 = EW'(in_data.elem_10) - EW'(in_data.elem_01);
    end else if (e00 > e11 && e00 > e22) begin
      sel = SEL_X; rad = one + e00 - e11 - e22;
      n0 = EW'(in_data.elem_21) - EW'(in_data.elem_12);
      n1 = EW'(in_data.elem_01) + EW'(in_data.elem_10);
      n2 = EW'(in_data.elem_02) + EW'(in_data.elem_20);
    end else if (e11 > e22) begin
      sel = SEL_Y; rad = one - e00 + e11 - e22;
      n0 = EW'(in_data.elem_02) - EW'(in_data.elem_20);
      n1 = EW'(in_data.elem_01) + EW'(in_data.elem_10);
      n2 = EW'(in_data.elem_12) + EW'(in_data.elem_21);
    end else begin
      sel = SEL_Z; rad = one - e00 - e11 + e22;
      n0 = EW'(in_data.elem_10) - EW'(in_data.elem_01);
      n1 = EW'(in_data.elem_02) + EW'(in_data.elem_20);
      n2 = EW'(in_data.elem_12) + EW'(in_data.elem_21);
    end
  end

  logic [SIW-1:0] s0_rad;
  logic [PW-1:0]  s0_pass;
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_rad  <= rad[EW-1] ? '0 : SIW'({rad[EW-2:0], {FRAC_BITS{1'b0}}});
      s0_pass <= {sel, n0, n1, n2};
    end
  end

  // Square root, held together with the rest of the pipe
  logic [RTW-1:0] root;
  logic [PW-1:0]  sq_pass;
  rmq_sqrt #(.IW(SIW), .PW(PW)) u_sqrt (
    .clk(clk), .en(adv), .rad(s0_rad), .pass_in(s0_pass), .root(root), .pass_out(sq_pass)
  );

  // Divisor and diagonal component
  logic [DVW-1:0] den;
  logic [RTW-1:0] half;
  logic [PW-1:0]  s1_pass;
  sel_t s1_sel;
  always_ff @(posedge clk) begin
    if (adv) begin
      half    <= root >> 1;
      den     <= (sel_t'(sq_pass[PW-1 -: 2]) == SEL_W) ? DVW'({root >> 1, 2'b00})
                                                      : DVW'({root, 1'b0});
      s1_pass <= sq_pass;
    end
  end
  assign s1_sel = sel_t'(s1_pass[PW-1 -: 2]);

  // Three divider lanes
  logic signed [DW-1:0] q0, q1, q2;
  rmq_div_lane #(.NW(EW), .DVW(DVW), .FB(FRAC_BITS), .DWP(DW)) u_l0 (
    .clk(clk), .en(adv), .num(s1_pass[3*EW-1 -: EW]), .den(den), .quo(q0));
  rmq_div_lane #(.NW(EW), .DVW(DVW), .FB(FRAC_BITS), .DWP(DW)) u_l1 (
    .clk(clk), .en(adv), .num(s1_pass[2*EW-1 -: EW]), .den(den), .quo(q1));
  rmq_div_lane #(.NW(EW), .DVW(DVW), .FB(FRAC_BITS), .DWP(DW)) u_l2 (
    .clk(clk), .en(adv), .num(s1_pass[EW-1:0]), .den(den), .quo(q2));

  // Carry sel, half-root and zero flag alongside the lanes
  logic [1:0]     ds_sel  [0:DVL];
  logic [RTW-1:0] ds_half [0:DVL];
  logic           ds_zero [0:DVL];
  assign ds_sel[0]  = s1_sel;
  assign ds_half[0] = half;
  assign ds_zero[0] = (den == '0);
  for (genvar i = 0; i < DVL; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (adv) begin
        ds_sel[i+1]  <= ds_sel[i];
        ds_half[i+1] <= ds_half[i];
        ds_zero[i+1] <= ds_zero[i];
      end
    end
  end

  // Merge lanes into component order
  logic signed [DW-1:0] hs;
  out_word_t mrg;
  assign hs = (ds_half[DVL] > RTW'((64'd1 << (DW-1)) - 1))
              ? {1'b0, {(DW-1){1'b1}}} : DW'(ds_half[DVL]);
  always_comb begin
    mrg = '0;
    case (sel_t'(ds_sel[DVL]))
      SEL_W: begin mrg.quat_w = DW'(hs); mrg.quat_x = DW'(q0);
                   mrg.quat_y = DW'(q1); mrg.quat_z = DW'(q2); end
      SEL_X: begin mrg.quat_w = DW'(q0); mrg.quat_x = DW'(hs);
                   mrg.quat_y = DW'(q1); mrg.quat_z = DW'(q2); end
      SEL_Y: begin mrg.quat_w = DW'(q0); mrg.quat_x = DW'(q1);
                   mrg.quat_y = DW'(hs); mrg.quat_z = DW'(q2); end
      default: begin mrg.quat_w = DW'(q0); mrg.quat_x = DW'(q1);
                   mrg.quat_y = DW'(q2); mrg.quat_z = DW'(hs); end
    endcase
    if (ds_zero[DVL]) begin
      mrg = '0;
      mrg.degenerate = 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= mrg;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[LAT-1];
    end
  end
endmodule
`default_nettype wire
